### hw/rtl/ltpc_pkg.sv
// Package for the texture page cache: shared constants, codes and types.
// Used by every module under hw/rtl. No dependencies.
`timescale 1ns / 1ps
package ltpc_pkg;

	localparam int SLOTS_SIDE     = 32;
	localparam int SLOT_W         = $clog2(SLOTS_SIDE);
	localparam int NSLOTS         = SLOTS_SIDE * SLOTS_SIDE;
	localparam int NSLOT_W        = $clog2(NSLOTS);
	localparam int MAX_LEVELS     = 7;
	localparam int LEVEL_W        = 3;
	localparam int BASE_SIDE_LOG2 = 6;
	localparam int MAP_DEPTH      = 5461;
	localparam int IDX_W          = $clog2(MAP_DEPTH);
	localparam int OFF_W          = IDX_W + 1;
	localparam int ENTRY_W        = NSLOT_W + 1;
	localparam int COUNT_W        = 11;
	localparam int CFG_W          = 3;

	// map entry codes; resident entries hold slot plus two
	localparam logic [ENTRY_W-1:0] MAP_ABSENT  = ENTRY_W'(0);
	localparam logic [ENTRY_W-1:0] MAP_PENDING = ENTRY_W'(1);

	// configuration register indexes
	localparam logic [1:0] CFG_NUM_LEVELS = 2'd0;
	localparam logic [1:0] CFG_X_LOG2     = 2'd1;
	localparam logic [1:0] CFG_Y_LOG2     = 2'd2;

	// input function codes
	localparam logic [1:0] FUNC_REQUEST = 2'd0;
	localparam logic [1:0] FUNC_SUBMIT  = 2'd1;
	localparam logic [1:0] FUNC_FLUSH   = 2'd2;

	typedef enum logic [1:0] {
		OP_REQ,
		OP_SUB,
		OP_FLUSH,
		OP_BAD
	} op_t;

	typedef enum logic [3:0] {
		ST_RANGE,
		ST_HIT,
		ST_PENDING,
		ST_FETCH,
		ST_DROPPED,
		ST_PLACED,
		ST_ALREADY,
		ST_NOTREQ,
		ST_FLUSHED
	} status_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_DECIDE,
		B_EVICT,
		B_MOVE1,
		B_MOVE2,
		B_OUT
	} bstate_t;

	// classified item handed from front to back
	typedef struct packed {
		op_t                op;
		logic [IDX_W-1:0]   idx;
		logic [LEVEL_W-1:0] level;
		logic               accepted;
	} item_t;

	// configuration registers
	typedef struct packed {
		logic [CFG_W-1:0] num_levels;
		logic [CFG_W-1:0] x_log2;
		logic [CFG_W-1:0] y_log2;
	} cfg_t;

endpackage

### hw/rtl/lru_texture_page_cache.sv
// Top level of the texture page cache: front, item queue and back.
// Depends on ltpc_pkg, ltpc_front, ltpc_queue, ltpc_back.
`timescale 1ns / 1ps
// Virtual-texture page cache with 32x32 slots in least-recently-used order.
// Input channel (in_valid/in_ready): func, mip_level, page_x, page_y,
// fetch_accepted. Output channel (out_valid/out_ready): one result item per
// input item: status, slot_x, slot_y, level_count, table_changed.
// Config channel (cfg_valid/cfg_ready): cfg_index 0..2 and cfg_data, always
// ready; write only while no item is in flight.
// The front checks range and computes the table index in the accept cycle
// and places the item in a two-entry queue. The back sequencer handles one
// item at a time with registered single-port reads of the page table and
// the link and owner memories. From IDLE a flush enters CLEAR and an
// out-of-range item goes straight to OUT; the rest pass DECIDE, a placement
// then EVICT, a hit or placement then MOVE1 and MOVE2, and all end in OUT.
// A flush sweeps the whole page table in CLEAR and then ends in OUT.
// After reset the same sweep runs and in_ready stays low meanwhile.
// When out_ready is low the result holds in the output register; the back
// stalls on the next result and the queue fills, then in_ready drops.
module lru_texture_page_cache (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [2:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [2:0]  mip_level,
	input  logic [5:0]  page_x,
	input  logic [5:0]  page_y,
	input  logic        fetch_accepted,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  status,
	output logic [4:0]  slot_x,
	output logic [4:0]  slot_y,
	output logic [10:0] level_count,
	output logic        table_changed
);

	ltpc_pkg::item_t fr_item, q_item;
	logic            q_full, q_not_empty, q_pop, init_busy;

	assign in_ready = !q_full && !init_busy;

	ltpc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.func           (func),
		.mip_level      (mip_level),
		.page_x         (page_x),
		.page_y         (page_y),
		.fetch_accepted (fetch_accepted),
		.item           (fr_item)
	);

	ltpc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid && in_ready),
		.push_item (fr_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_item (q_item)
	);

	ltpc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_not_empty   (q_not_empty),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.init_busy     (init_busy),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.slot_x        (slot_x),
		.slot_y        (slot_y),
		.level_count   (level_count),
		.table_changed (table_changed)
	);

endmodule

### hw/rtl/ltpc_front.sv
// Front part: configuration registers, range check and page table index.
// Depends on ltpc_pkg.
`timescale 1ns / 1ps
module ltpc_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [ltpc_pkg::CFG_W-1:0]  cfg_data,
	input  logic [1:0]                  func,
	input  logic [2:0]                  mip_level,
	input  logic [5:0]                  page_x,
	input  logic [5:0]                  page_y,
	input  logic                        fetch_accepted,
	output ltpc_pkg::item_t             item
);

	ltpc_pkg::cfg_t cfg_q;

	// saturated side exponent of a level
	function automatic logic [2:0] side_exp(input logic [2:0] lg, input logic [2:0] lvl);
		logic [2:0] l;
		l = (lg > 3'(ltpc_pkg::BASE_SIDE_LOG2)) ? 3'(ltpc_pkg::BASE_SIDE_LOG2) : lg;
		return (l > lvl) ? (l - lvl) : 3'd0;
	endfunction

	assign cfg_ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_levels <= 3'd7;
			cfg_q.x_log2     <= 3'd6;
			cfg_q.y_log2     <= 3'd6;
		end else if (cfg_valid) begin
			case (cfg_index)
				ltpc_pkg::CFG_NUM_LEVELS: cfg_q.num_levels <= cfg_data;
				ltpc_pkg::CFG_X_LOG2:     cfg_q.x_log2     <= cfg_data;
				ltpc_pkg::CFG_Y_LOG2:     cfg_q.y_log2     <= cfg_data;
				default: ;
			endcase
		end
	end

	// level offset, bounds and table index
	logic [ltpc_pkg::OFF_W-1:0] off;
	logic [2:0]                 ex, ey, levels;
	logic                       in_range;

	always_comb begin
		off = '0;
		for (int l = 0; l < ltpc_pkg::MAX_LEVELS; l++) begin
			if (3'(l) < mip_level)
				off = off + (ltpc_pkg::OFF_W'(1) << (4'(side_exp(cfg_q.x_log2, 3'(l)))
					+ 4'(side_exp(cfg_q.y_log2, 3'(l)))));
		end
		ex = side_exp(cfg_q.x_log2, mip_level);
		ey = side_exp(cfg_q.y_log2, mip_level);
		off = off + (ltpc_pkg::OFF_W'(page_y) << ex) + ltpc_pkg::OFF_W'(page_x);
		levels = (cfg_q.num_levels > 3'(ltpc_pkg::MAX_LEVELS)) ?
			3'(ltpc_pkg::MAX_LEVELS) : cfg_q.num_levels;
		in_range = (mip_level < levels) && (7'(page_x) < (7'd1 << ex))
			&& (7'(page_y) < (7'd1 << ey)) && (off < ltpc_pkg::OFF_W'(ltpc_pkg::MAP_DEPTH));
	end

	// classification
	always_comb begin
		item.idx      = off[ltpc_pkg::IDX_W-1:0];
		item.level    = mip_level;
		item.accepted = fetch_accepted;
		case (func)
			ltpc_pkg::FUNC_FLUSH:   item.op = ltpc_pkg::OP_FLUSH;
			ltpc_pkg::FUNC_REQUEST: item.op = in_range ? ltpc_pkg::OP_REQ : ltpc_pkg::OP_BAD;
			ltpc_pkg::FUNC_SUBMIT:  item.op = in_range ? ltpc_pkg::OP_SUB : ltpc_pkg::OP_BAD;
			default:                item.op = ltpc_pkg::OP_BAD;
		endcase
	end

endmodule

### hw/rtl/ltpc_queue.sv
// Two-entry queue of classified items between front and back.
// Depends on ltpc_pkg.
`timescale 1ns / 1ps
module ltpc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ltpc_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output ltpc_pkg::item_t head_item
);

	ltpc_pkg::item_t ent_q [2];
	logic            wr_q, rd_q;
	logic [1:0]      cnt_q;

	assign full      = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign head_item = ent_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= push_item;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

### hw/rtl/ltpc_back.sv
// Back part: page table, LRU links, slot owners, counts and result register.
// Depends on ltpc_pkg.
`timescale 1ns / 1ps
module ltpc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_not_empty,
	input  ltpc_pkg::item_t q_item,
	output logic            q_pop,
	output logic            init_busy,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [3:0]      status,
	output logic [4:0]      slot_x,
	output logic [4:0]      slot_y,
	output logic [10:0]     level_count,
	output logic            table_changed
);

	localparam int NW = ltpc_pkg::NSLOT_W;
	localparam int EW = ltpc_pkg::ENTRY_W;
	localparam int IW = ltpc_pkg::IDX_W;
	localparam int LW = ltpc_pkg::LEVEL_W;
	localparam int OW = 1 + IW + LW;

	ltpc_pkg::bstate_t st_q, st_nx;
	ltpc_pkg::item_t   item_q;
	ltpc_pkg::status_t stat_q;
	logic              has_slot_q, flush_q, dirty_q;
	logic [IW-1:0]     clr_q;
	logic [NW-1:0]     slot_q, head_q, tail_q;
	logic [ltpc_pkg::COUNT_W-1:0] cnt_q [ltpc_pkg::MAX_LEVELS];

	// memories
	logic [EW-1:0] map_mem [ltpc_pkg::MAP_DEPTH];
	logic [NW-1:0] lru_mem [ltpc_pkg::NSLOTS];
	logic [NW-1:0] mru_mem [ltpc_pkg::NSLOTS];
	logic [OW-1:0] own_mem [ltpc_pkg::NSLOTS];

	logic [EW-1:0] map_rd_q;
	logic [NW-1:0] lru_rd_q, mru_rd_q;
	logic [OW-1:0] own_rd_q;

	logic          map_we, lru_we, mru_we, own_we, link_re;
	logic [IW-1:0] map_wa;
	logic [EW-1:0] map_wd;
	logic [NW-1:0] lru_wa, lru_wd, mru_wa, mru_wd, own_wa, link_ra;
	logic [OW-1:0] own_wd;

	logic          out_free, cnt_dec, cnt_inc;
	logic [NW-1:0] ent_slot;
	logic          own_valid;
	logic [IW-1:0] own_idx;
	logic [LW-1:0] own_lv;

	assign out_free  = !out_valid || out_ready;
	assign ent_slot  = NW'(map_rd_q - EW'(2));
	assign own_valid = own_rd_q[OW-1];
	assign own_idx   = own_rd_q[OW-2 -: IW];
	assign own_lv    = own_rd_q[LW-1:0];
	assign init_busy = (st_q == ltpc_pkg::B_CLEAR) && !flush_q;
	assign q_pop     = (st_q == ltpc_pkg::B_IDLE) && q_not_empty;

	always_ff @(posedge clk) begin
		if (map_we) map_mem[map_wa] <= map_wd;
		if (q_pop)  map_rd_q <= map_mem[q_item.idx];
	end

	always_ff @(posedge clk) begin
		if (lru_we) lru_mem[lru_wa] <= lru_wd;
		if (mru_we) mru_mem[mru_wa] <= mru_wd;
		if (own_we) own_mem[own_wa] <= own_wd;
		if (link_re) begin
			lru_rd_q <= lru_mem[link_ra];
			mru_rd_q <= mru_mem[link_ra];
			own_rd_q <= own_mem[link_ra];
		end
	end

	// next state
	always_comb begin
		st_nx = st_q;
		case (st_q)
			ltpc_pkg::B_CLEAR:
				if (clr_q == IW'(ltpc_pkg::MAP_DEPTH - 1))
					st_nx = flush_q ? ltpc_pkg::B_OUT : ltpc_pkg::B_IDLE;
			ltpc_pkg::B_IDLE:
				if (q_not_empty) begin
					case (q_item.op)
						ltpc_pkg::OP_FLUSH: st_nx = ltpc_pkg::B_CLEAR;
						ltpc_pkg::OP_BAD:   st_nx = ltpc_pkg::B_OUT;
						default:            st_nx = ltpc_pkg::B_DECIDE;
					endcase
				end
			ltpc_pkg::B_DECIDE:
				if (map_rd_q == ltpc_pkg::MAP_ABSENT) st_nx = ltpc_pkg::B_OUT;
				else if (map_rd_q == ltpc_pkg::MAP_PENDING)
					st_nx = (item_q.op == ltpc_pkg::OP_SUB) ? ltpc_pkg::B_EVICT : ltpc_pkg::B_OUT;
				else
					st_nx = (item_q.op == ltpc_pkg::OP_REQ) ? ltpc_pkg::B_MOVE1 : ltpc_pkg::B_OUT;
			ltpc_pkg::B_EVICT: st_nx = ltpc_pkg::B_MOVE1;
			ltpc_pkg::B_MOVE1: st_nx = ltpc_pkg::B_MOVE2;
			ltpc_pkg::B_MOVE2: st_nx = ltpc_pkg::B_OUT;
			ltpc_pkg::B_OUT:   if (out_free) st_nx = ltpc_pkg::B_IDLE;
			default:           st_nx = ltpc_pkg::B_IDLE;
		endcase
	end

	// memory ports and count updates
	always_comb begin
		map_we  = 1'b0; map_wa = item_q.idx; map_wd = ltpc_pkg::MAP_ABSENT;
		lru_we  = 1'b0; lru_wa = slot_q; lru_wd = head_q;
		mru_we  = 1'b0; mru_wa = head_q; mru_wd = slot_q;
		own_we  = 1'b0; own_wa = slot_q; own_wd = {1'b1, item_q.idx, item_q.level};
		link_re = 1'b0; link_ra = tail_q;
		cnt_dec = 1'b0; cnt_inc = 1'b0;
		case (st_q)
			ltpc_pkg::B_CLEAR: begin
				map_we = 1'b1;
				map_wa = clr_q;
				if (clr_q < IW'(ltpc_pkg::NSLOTS)) begin
					lru_we = 1'b1; lru_wa = NW'(clr_q); lru_wd = NW'(clr_q + IW'(1));
					mru_we = 1'b1; mru_wa = NW'(clr_q);
					mru_wd = (clr_q == '0) ? '0 : NW'(clr_q - IW'(1));
					own_we = 1'b1; own_wa = NW'(clr_q); own_wd = '0;
				end
			end
			ltpc_pkg::B_DECIDE: begin
				if (item_q.op == ltpc_pkg::OP_REQ && map_rd_q == ltpc_pkg::MAP_ABSENT
						&& item_q.accepted) begin
					map_we = 1'b1;
					map_wd = ltpc_pkg::MAP_PENDING;
				end
				link_re = 1'b1;
				link_ra = (map_rd_q == ltpc_pkg::MAP_PENDING) ? tail_q : ent_slot;
			end
			ltpc_pkg::B_EVICT: begin
				if (own_valid) begin
					map_we  = own_idx < IW'(ltpc_pkg::MAP_DEPTH);
					map_wa  = own_idx;
					cnt_dec = 1'b1;
				end
			end
			ltpc_pkg::B_MOVE1: begin
				// unlink the slot from its neighbors
				if (slot_q != head_q && slot_q != tail_q) begin
					lru_we = 1'b1; lru_wa = mru_rd_q; lru_wd = lru_rd_q;
					mru_we = 1'b1; mru_wa = lru_rd_q; mru_wd = mru_rd_q;
				end
			end
			ltpc_pkg::B_MOVE2: begin
				// relink at the MRU end, place a submitted page
				if (slot_q != head_q) begin
					lru_we = 1'b1;
					mru_we = 1'b1;
				end
				if (item_q.op == ltpc_pkg::OP_SUB) begin
					map_we  = 1'b1;
					map_wd  = EW'(slot_q) + EW'(2);
					own_we  = 1'b1;
					cnt_inc = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ltpc_pkg::B_CLEAR;
			flush_q    <= 1'b0;
			clr_q      <= '0;
			head_q     <= '0;
			tail_q     <= NW'(ltpc_pkg::NSLOTS - 1);
			dirty_q    <= 1'b1;
			stat_q     <= ltpc_pkg::ST_RANGE;
			has_slot_q <= 1'b0;
			slot_q     <= '0;
			out_valid  <= 1'b0;
			item_q     <= '0;
		end else begin
			st_q <= st_nx;
			if (st_q == ltpc_pkg::B_OUT && out_free) out_valid <= 1'b1;
			else if (out_ready)                      out_valid <= 1'b0;
			case (st_q)
				ltpc_pkg::B_CLEAR: begin
					clr_q  <= clr_q + IW'(1);
					head_q <= '0;
					tail_q <= NW'(ltpc_pkg::NSLOTS - 1);
					stat_q <= ltpc_pkg::ST_FLUSHED;
					has_slot_q <= 1'b0;
					if (clr_q == IW'(ltpc_pkg::MAP_DEPTH - 1)) dirty_q <= 1'b1;
				end
				ltpc_pkg::B_IDLE:
					if (q_not_empty) begin
						item_q     <= q_item;
						clr_q      <= '0;
						flush_q    <= q_item.op == ltpc_pkg::OP_FLUSH;
						stat_q     <= ltpc_pkg::ST_RANGE;
						has_slot_q <= 1'b0;
					end
				ltpc_pkg::B_DECIDE:
					if (item_q.op == ltpc_pkg::OP_REQ) begin
						if (map_rd_q == ltpc_pkg::MAP_ABSENT)
							stat_q <= item_q.accepted ? ltpc_pkg::ST_FETCH : ltpc_pkg::ST_DROPPED;
						else if (map_rd_q == ltpc_pkg::MAP_PENDING)
							stat_q <= ltpc_pkg::ST_PENDING;
						else begin
							stat_q <= ltpc_pkg::ST_HIT; has_slot_q <= 1'b1; slot_q <= ent_slot;
						end
					end else begin
						if (map_rd_q == ltpc_pkg::MAP_ABSENT)
							stat_q <= ltpc_pkg::ST_NOTREQ;
						else if (map_rd_q == ltpc_pkg::MAP_PENDING) begin
							stat_q <= ltpc_pkg::ST_PLACED; has_slot_q <= 1'b1; slot_q <= tail_q;
						end else begin
							stat_q <= ltpc_pkg::ST_ALREADY; has_slot_q <= 1'b1; slot_q <= ent_slot;
						end
					end
				ltpc_pkg::B_MOVE1:
					if (slot_q != head_q && slot_q == tail_q) tail_q <= mru_rd_q;
				ltpc_pkg::B_MOVE2: begin
					head_q <= slot_q;
					if (item_q.op == ltpc_pkg::OP_SUB) dirty_q <= 1'b1;
				end
				ltpc_pkg::B_OUT:
					if (out_free) dirty_q <= 1'b0;
				default: ;
			endcase
		end
	end

	// per-level resident counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ltpc_pkg::MAX_LEVELS; i++) cnt_q[i] <= '0;
		end else begin
			for (int i = 0; i < ltpc_pkg::MAX_LEVELS; i++) begin
				if (st_q == ltpc_pkg::B_CLEAR) cnt_q[i] <= '0;
				else if (cnt_dec && own_lv == LW'(i) && cnt_q[i] != '0)
					cnt_q[i] <= cnt_q[i] - 1'b1;
				else if (cnt_inc && item_q.level == LW'(i))
					cnt_q[i] <= cnt_q[i] + 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (st_q == ltpc_pkg::B_OUT && out_free) begin
			status        <= stat_q;
			slot_x        <= has_slot_q ? slot_q[ltpc_pkg::SLOT_W-1:0] : '0;
			slot_y        <= has_slot_q ? 5'(slot_q >> ltpc_pkg::SLOT_W) : '0;
			level_count   <= (item_q.level < LW'(ltpc_pkg::MAX_LEVELS)) ?
				cnt_q[item_q.level] : '0;
			table_changed <= dirty_q;
		end
	end

endmodule
